// File: sv/declcg_pkg.sv
// Shared constants, command codes, datapath operation codes and helpers for the decimal LCG.
package declcg_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned SEED_W  = 32;
  localparam int unsigned RANGE_W = 16;
  localparam int unsigned QUOT_W  = 19;  // quotient of a 32-bit value by 10000
  localparam int unsigned DIGIT_W = 14;  // one base-10000 digit
  localparam int unsigned WORK_W  = 30;  // mix sum, pre-wrap seed and scaled draw

  localparam int unsigned TEN_K      = 10000;
  localparam int unsigned DEC_MOD    = 100000000;
  localparam int unsigned MULT_HI    = 3141;  // upper base-10000 digit of 31415821
  localparam int unsigned MULT_LO    = 5821;  // lower base-10000 digit of 31415821
  localparam int unsigned BYTE_RANGE = 256;

  // x / 10000 == (x * ceil(2^45 / 10000)) >> 45, exact for every 32-bit x.
  localparam logic [63:0] QUOT_MAGIC = 64'd3518437209;
  localparam int unsigned QUOT_SHIFT = 45;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_RANGED = 2'd1,
    CMD_WORD   = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    OP_NOP        = 4'd0,
    OP_ACCEPT     = 4'd1,
    OP_Q_SEED     = 4'd2,
    OP_R_SEED     = 4'd3,
    OP_Q_A        = 4'd4,
    OP_R_A        = 4'd5,
    OP_MIX        = 4'd6,
    OP_Q_W        = 4'd7,
    OP_R_W        = 4'd8,
    OP_SUM        = 4'd9,
    OP_WRAP       = 4'd10,
    OP_PROD       = 4'd11,
    OP_PACK       = 4'd12,
    OP_OUT_RANGED = 4'd13,
    OP_OUT_WORD   = 4'd14
  } dp_op_t;

  function automatic logic [QUOT_W-1:0] quot_10k(input logic [SEED_W-1:0] x);
    logic [63:0] p;
    p = 64'(x) * QUOT_MAGIC;
    return p[QUOT_SHIFT +: QUOT_W];
  endfunction

endpackage

// File: sv/decimal_lcg_random_words_core.sv
// Top level of the decimal linear congruential random word generator.
//
// This block holds one seed and steps it as seed = (seed * 31415821 + 1) mod 100000000,
// with the product formed exactly from the whole 32-bit unsigned seed. Each input transfer
// carries a command in in_tuser: load (the seed takes seed_value, no result), ranged draw
// (one step, result floor(floor(seed / 10000) * range / 10000)), or word draw (four ranged
// draws with range 256 packed into 32 bits, first draw in the highest byte). Command code 3
// is accepted and ignored. One item is worked at a time; in_tready is high only while the
// controller is idle. Each draw runs the seed update through S_QS, S_RS, S_QA, S_RA, S_MIX,
// S_QW, S_RW, S_SUM and S_WRAP, then scales the draw and hands it on through S_HI, S_PROD,
// S_DRAW and S_OUT, in turn, because a single divide-by-10000 step (a reciprocal multiply
// followed by a remainder multiply) is shared by the seed update and the scaling of the
// draw. A word draw moves the packed word out from S_OUT once its last byte is packed. The
// result sits in an output register, so the next item is taken while an earlier result
// still waits for its output transfer; a draw that finishes while that register is still
// full waits in its last state until the register frees up.
module decimal_lcg_random_words_core import declcg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] seed_value, [47:32] range
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] value
);

  dp_op_t op;

  // The controller sequences the steps; the datapath holds the seed and does the arithmetic.
  declcg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .cmd       (in_tuser),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .op        (op)
  );

  declcg_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .cmd        (in_tuser),
    .seed_value (in_tdata[31:0]),
    .range      (in_tdata[47:32]),
    .value      (out_tdata)
  );

endmodule

// File: sv/declcg_dp.sv
// Datapath of the decimal LCG: seed, digit registers, divide-by-10000 step and output word.
module declcg_dp import declcg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_op_t             op,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [SEED_W-1:0]  seed_value,
  input  logic [RANGE_W-1:0] range,
  output logic [SEED_W-1:0]  value
);

  logic [SEED_W-1:0]  seed_r, seed_nxt;
  logic [QUOT_W-1:0]  q_r, q_nxt;
  logic [QUOT_W-1:0]  a_r, a_nxt;
  logic [DIGIT_W-1:0] b_r, b_nxt;
  logic [WORK_W-1:0]  w_r, w_nxt;
  logic [RANGE_W-1:0] range_r, range_nxt;
  logic [SEED_W-1:0]  word_r, word_nxt;
  logic [SEED_W-1:0]  value_r, value_nxt;
  logic [SEED_W-1:0]  qk;

  // Quotient times 10000, subtracted from the dividend to give the remainder.
  assign qk = 32'(q_r) * 32'(TEN_K);

  always_comb begin
    seed_nxt  = seed_r;
    q_nxt     = q_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    w_nxt     = w_r;
    range_nxt = range_r;
    word_nxt  = word_r;
    value_nxt = value_r;
    case (op)
      OP_ACCEPT: begin
        if (cmd_t'(cmd) == CMD_LOAD) seed_nxt = seed_value;
        range_nxt = (cmd_t'(cmd) == CMD_WORD) ? RANGE_W'(BYTE_RANGE) : range;
      end
      OP_Q_SEED: q_nxt = quot_10k(seed_r);
      OP_R_SEED: begin
        b_nxt = DIGIT_W'(seed_r - qk);
        a_nxt = q_r;
      end
      OP_Q_A: q_nxt = quot_10k(32'(a_r));
      OP_R_A: a_nxt = QUOT_W'(32'(a_r) - qk);
      OP_MIX: w_nxt = WORK_W'(30'(a_r[DIGIT_W-1:0]) * 30'(MULT_LO)
                              + 30'(b_r) * 30'(MULT_HI));
      OP_Q_W: q_nxt = quot_10k(32'(w_r));
      OP_R_W: w_nxt = WORK_W'(32'(w_r) - qk);
      OP_SUM: w_nxt = WORK_W'(30'(b_r) * 30'(MULT_LO)
                              + 30'(w_r[DIGIT_W-1:0]) * 30'(TEN_K) + 30'd1);
      OP_WRAP: begin
        if (32'(w_r) >= 32'(DEC_MOD)) seed_nxt = 32'(w_r) - 32'(DEC_MOD);
        else seed_nxt = 32'(w_r);
      end
      OP_PROD: w_nxt = WORK_W'(30'(q_r[DIGIT_W-1:0]) * 30'(range_r));
      OP_PACK: word_nxt = {word_r[SEED_W-9:0], q_r[7:0]};
      OP_OUT_RANGED: value_nxt = 32'(q_r);
      OP_OUT_WORD: value_nxt = word_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r     <= q_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    w_r     <= w_nxt;
    range_r <= range_nxt;
    word_r  <= word_nxt;
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

// File: sv/declcg_ctrl.sv
// Controller of the decimal LCG: sequences the datapath and runs both stream handshakes.
module declcg_ctrl import declcg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output dp_op_t           op
);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_QS   = 14'b00000000000010,
    S_RS   = 14'b00000000000100,
    S_QA   = 14'b00000000001000,
    S_RA   = 14'b00000000010000,
    S_MIX  = 14'b00000000100000,
    S_QW   = 14'b00000001000000,
    S_RW   = 14'b00000010000000,
    S_SUM  = 14'b00000100000000,
    S_WRAP = 14'b00001000000000,
    S_HI   = 14'b00010000000000,
    S_PROD = 14'b00100000000000,
    S_DRAW = 14'b01000000000000,
    S_OUT  = 14'b10000000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       is_word_r, is_word_nxt;
  logic       out_valid_r, out_valid_nxt;
  // Marks that the word marker was cleared after the last byte was packed.
  logic       word_done_r, word_done_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    is_word_nxt   = is_word_r;
    out_valid_nxt = out_valid_r && !out_ready;
    op            = OP_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op          = OP_ACCEPT;
          cnt_nxt     = 2'd0;
          is_word_nxt = (cmd_t'(cmd) == CMD_WORD);
          if (cmd_t'(cmd) inside {CMD_RANGED, CMD_WORD}) state_nxt = S_QS;
        end
      end
      S_QS: begin
        op        = OP_Q_SEED;
        state_nxt = S_RS;
      end
      S_RS: begin
        op        = OP_R_SEED;
        state_nxt = S_QA;
      end
      S_QA: begin
        op        = OP_Q_A;
        state_nxt = S_RA;
      end
      S_RA: begin
        op        = OP_R_A;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        op        = OP_MIX;
        state_nxt = S_QW;
      end
      S_QW: begin
        op        = OP_Q_W;
        state_nxt = S_RW;
      end
      S_RW: begin
        op        = OP_R_W;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        op        = OP_SUM;
        state_nxt = S_WRAP;
      end
      S_WRAP: begin
        op        = OP_WRAP;
        state_nxt = S_HI;
      end
      S_HI: begin
        op        = OP_Q_SEED;
        state_nxt = S_PROD;
      end
      S_PROD: begin
        op        = OP_PROD;
        state_nxt = S_DRAW;
      end
      S_DRAW: begin
        op        = OP_Q_W;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (is_word_r && cnt_r != 2'd3) begin
          // Shift this byte in and start the next draw of the word.
          op        = OP_PACK;
          cnt_nxt   = cnt_r + 2'd1;
          state_nxt = S_QS;
        end else if (is_word_r && cnt_r == 2'd3) begin
          op        = OP_PACK;
          cnt_nxt   = 2'd0;
          is_word_nxt = 1'b0;
          state_nxt = S_OUT;
          // The packed word goes out from this state once the output register is free,
          // flagged by the cleared word marker and the set word_done flag.
        end else if (!out_valid_r || out_ready) begin
          op            = (cnt_r == 2'd0 && !is_word_r && !word_done_r) ? OP_OUT_RANGED
                                                                         : OP_OUT_WORD;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    word_done_nxt = word_done_r;
    if (state_r == S_IDLE) word_done_nxt = 1'b0;
    if (state_r == S_OUT && is_word_r && cnt_r == 2'd3) word_done_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 2'd0;
      is_word_r   <= 1'b0;
      out_valid_r <= 1'b0;
      word_done_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      is_word_r   <= is_word_nxt;
      out_valid_r <= out_valid_nxt;
      word_done_r <= word_done_nxt;
    end
  end

endmodule

// File: bench/tb_decimal_lcg_random_words_core.sv
// Self-checking testbench for the decimal LCG random word generator core.
`timescale 1ns / 100ps

module tb_decimal_lcg_random_words_core;
  import declcg_pkg::*;

  // The command code that the block accepts and then ignores.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Generator constants, kept here so that the expected values do not lean on the RTL.
  localparam longint unsigned LCG_MULTIPLIER = 64'd31415821;
  localparam longint unsigned DECIMAL_MOD    = 64'd100000000;
  localparam longint unsigned HALF_SPLIT     = 64'd10000;
  localparam logic [15:0]     WORD_BYTE_SPAN = 16'd256;

  // A quiet spell this long, far beyond the time a word draw takes, means a hang.
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned DRAIN_TAIL  = 100;
  localparam int unsigned MAX_REPORTS = 10;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // [31:0] seed_value, [47:32] range
  logic [1:0]  in_tuser;   // [1:0] cmd
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] value

  // Our own copy of the generator seed, advanced as each input transfer is accepted.
  logic [31:0] model_seed;
  // Values that the block still owes us, oldest first.
  logic [31:0] pending_values[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned fail_count;
  int unsigned report_count;
  int unsigned quiet_cycles;

  decimal_lcg_random_words_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // One step of the generator: the whole 32-bit seed is folded into the decimal
  // modulus first, so seeds of 100000000 and above are handled exactly.
  function automatic logic [31:0] next_decimal_seed(input logic [31:0] seed);
    longint unsigned prod;
    prod = ((64'(seed) % DECIMAL_MOD) * LCG_MULTIPLIER) % DECIMAL_MOD;
    return 32'((prod + 64'd1) % DECIMAL_MOD);
  endfunction

  // Steps the model seed and scales its upper four decimal digits into [0, span).
  function automatic logic [31:0] scaled_draw(input logic [15:0] span);
    longint unsigned upper;
    model_seed = next_decimal_seed(model_seed);
    upper = 64'(model_seed) / HALF_SPLIT;
    return 32'((upper * 64'(span)) / HALF_SPLIT);
  endfunction

  // Applies one accepted command to the model and queues any value it produces.
  task automatic predict_command(input logic [1:0] cmd, input logic [31:0] seed,
                                 input logic [15:0] span);
    logic [31:0] word;
    logic [31:0] byte_draw;
    word = '0;
    case (cmd)
      CMD_LOAD: begin
        model_seed = seed;
      end
      CMD_RANGED: begin
        pending_values.push_back(scaled_draw(span));
      end
      CMD_WORD: begin
        // The first byte drawn ends up in the highest byte of the word.
        for (int k = 0; k < 4; k++) begin
          byte_draw = scaled_draw(WORD_BYTE_SPAN);
          word = {word[23:0], byte_draw[7:0]};
        end
        pending_values.push_back(word);
      end
      default: begin
      end
    endcase
  endtask

  // Presents one command, with random idle cycles ahead of it, and holds it until the
  // transfer happens. in_tvalid stays high when the next command follows at once.
  task automatic send_command(input logic [1:0] cmd, input logic [31:0] seed,
                              input logic [15:0] span);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {span, seed};
    do @(posedge clk); while (!in_tready);
    predict_command(cmd, seed, span);
  endtask

  function automatic logic [31:0] pick_seed();
    logic [31:0] corners[5];
    corners = '{32'd0, 32'd99999999, 32'd100000000, 32'h8000_0000, 32'hFFFF_FFFF};
    case ($urandom_range(2))
      0:       return $urandom;
      1:       return $urandom_range(99999999);
      default: return corners[$urandom_range(4)];
    endcase
  endfunction

  function automatic logic [15:0] pick_span();
    case ($urandom_range(4))
      0:       return 16'(($urandom_range(1) == 0) ? 0 : 16'hFFFF);
      1:       return 16'($urandom_range(300));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // Output side: out_tready follows the current stall rate, one decision per cycle.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every output transfer is matched against the oldest outstanding value.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_values.size() == 0) begin
        fail_count++;
        if (report_count < MAX_REPORTS) begin
          report_count++;
          $display("unexpected result: value %h with nothing outstanding", out_tdata);
        end
      end else begin
        if (out_tdata !== pending_values[0]) begin
          fail_count++;
          if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("value mismatch: expected %h, got %h", pending_values[0], out_tdata);
          end
        end
        void'(pending_values.pop_front());
      end
    end
  end

  // Watchdog: a long spell with no transfer on either side ends the run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Field extremes, the seed-above-modulus and top-bit cases, and range zero.
  task automatic test_seed_and_range_extremes();
    send_command(CMD_RANGED, 32'h0, 16'hFFFF);      // first step from the reset seed
    send_command(CMD_LOAD, 32'hFFFF_FFFF, 16'h0);
    send_command(CMD_RANGED, 32'h0, 16'h0);         // range zero still steps
    send_command(CMD_RANGED, 32'h0, 16'hFFFF);
    send_command(CMD_LOAD, 32'h8000_0000, 16'hFFFF);
    send_command(CMD_RANGED, 32'hFFFF_FFFF, 16'h1);
    send_command(CMD_LOAD, 32'd100000000, 16'h0);
    send_command(CMD_RANGED, 32'h0, 16'h8000);
    send_command(CMD_LOAD, 32'd99999999, 16'h0);
    send_command(CMD_RANGED, 32'h0, 16'h5555);
    send_command(CMD_RANGED, 32'h0, 16'hAAAA);
  endtask

  // Packed word draws from a few loaded seeds, including one with the top bit set.
  task automatic test_word_draws();
    send_command(CMD_LOAD, 32'h0, 16'h0);
    send_command(CMD_WORD, 32'h0, 16'h0);
    send_command(CMD_LOAD, 32'hAAAA_AAAA, 16'h0);
    send_command(CMD_WORD, 32'h5555_5555, 16'hFFFF);
    send_command(CMD_WORD, 32'hFFFF_FFFF, 16'h1234);
  endtask

  // Code 3 must leave the seed alone; the draws after it prove that.
  task automatic test_unused_command();
    send_command(CMD_LOAD, 32'd12345678, 16'h0);
    send_command(CMD_UNUSED, $urandom, 16'($urandom));
    send_command(CMD_RANGED, 32'h0, 16'hFFFF);
    send_command(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    send_command(CMD_WORD, 32'h0, 16'h0);
  endtask

  // Random mix of commands under one idling and stalling setting. Ignored commands are sprinkled
  // in and count toward the item total like the others.
  task automatic test_random_mix(input int unsigned n_items, input int unsigned idle_pct,
                                 input int unsigned stall_pct);
    int unsigned sent;
    int unsigned pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        send_command(CMD_LOAD, pick_seed(), pick_span());
      end else if (pick < 60) begin
        send_command(CMD_RANGED, pick_seed(), pick_span());
      end else if (pick < 90) begin
        send_command(CMD_WORD, pick_seed(), pick_span());
      end else begin
        send_command(CMD_UNUSED, pick_seed(), pick_span());
      end
      sent++;
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    in_tuser       <= '0;
    model_seed     = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_seed_and_range_extremes();
    test_word_draws();
    test_unused_command();
    test_random_mix(400, 0, 0);
    test_random_mix(400, 54, 0);
    test_random_mix(400, 0, 54);
    test_random_mix(400, 30, 30);

    // Drain: the watchdog covers a result that never shows up.
    in_tvalid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
